// ----- sv/zmodem_sender_flow_control_top_assert.svh -----
// Assertion macros for the Zmodem sender flow-control block.
// Included by the port checker; needs nothing else.
`ifndef ZMODEM_SENDER_FLOW_CONTROL_TOP_ASSERT_SVH
`define ZMODEM_SENDER_FLOW_CONTROL_TOP_ASSERT_SVH

// Checked property, switched off while reset is held.
`define ZSFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also covers the reset cycles.
`define ZSFC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/zsfc_pkg.sv -----
// Shared types, codes and constants of the Zmodem sender flow-control block.
// Used by the front, back, top level and checker; depends on nothing.
package zsfc_pkg;

  // Widths and limits
  localparam int POS_BITS    = 31;
  localparam int MAX_BLOCK   = 8192;
  localparam int MIN_BLOCK   = 32;
  localparam int BLK_W       = 14;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int FILL_W      = 17;
  localparam int RETRY_W     = 4;
  localparam int JUNK_W      = 3;
  localparam int RETRY_FATAL = 12;
  localparam int RETRY_HALVE = 4;
  localparam int RETRY_MAX   = 15;
  localparam int JUNK_LIMIT  = 3;
  localparam int JUNK_SAT    = 4;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);

  // Raw action codes on the input channel
  localparam logic [2:0] ACT_SET_POS   = 3'd0;
  localparam logic [2:0] ACT_BEGIN_HDR = 3'd1;
  localparam logic [2:0] ACT_BLOCK     = 3'd2;
  localparam logic [2:0] ACT_HEADER    = 3'd3;
  localparam logic [2:0] ACT_JUNK      = 3'd4;

  // Raw frame kinds of a received header
  localparam logic [2:0] FRK_ACK    = 3'd0;
  localparam logic [2:0] FRK_REPOS  = 3'd1;
  localparam logic [2:0] FRK_RINIT  = 3'd2;
  localparam logic [2:0] FRK_SKIP   = 3'd3;
  localparam logic [2:0] FRK_FATAL  = 3'd4;
  localparam logic [2:0] FRK_HANGUP = 3'd5;

  // Subpacket end codes
  localparam logic [2:0] SUB_NONE = 3'd0;
  localparam logic [2:0] SUB_CRCG = 3'd1;
  localparam logic [2:0] SUB_CRCQ = 3'd2;
  localparam logic [2:0] SUB_CRCW = 3'd3;
  localparam logic [2:0] SUB_CRCE = 3'd4;

  // Verdict codes
  localparam logic [3:0] VRD_NONE      = 4'd0;
  localparam logic [3:0] VRD_KEEP_WAIT = 4'd1;
  localparam logic [3:0] VRD_NAK_WAIT  = 4'd2;
  localparam logic [3:0] VRD_ACKED     = 4'd3;
  localparam logic [3:0] VRD_RESEND    = 4'd4;
  localparam logic [3:0] VRD_RX_AHEAD  = 4'd5;
  localparam logic [3:0] VRD_SKIP      = 4'd6;
  localparam logic [3:0] VRD_RINIT     = 4'd7;
  localparam logic [3:0] VRD_FATAL     = 4'd8;
  localparam logic [3:0] VRD_HANGUP    = 4'd9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RX_BUFFER_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_WINDOW       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_SPACING     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BLOCK_LEN = 2'd3;

  // Reset value of the block length
  localparam logic [BLK_W-1:0] BLK_RESET = 14'd1024;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET_POS,
    OP_BEGIN_HDR,
    OP_BLOCK,
    OP_HEADER,
    OP_JUNK
  } op_t;

  // Classified frame kind
  typedef enum logic [2:0] {
    FR_ACK,
    FR_REPOS,
    FR_RINIT,
    FR_SKIP,
    FR_FATAL,
    FR_HANGUP,
    FR_OTHER
  } frame_t;

  // Input transfer payload
  typedef struct packed {
    logic [2:0]          action;
    logic [BLK_W-1:0]    block_bytes;
    logic                end_of_file;
    logic [2:0]          frame_kind;
    logic [POS_BITS-1:0] frame_position;
    logic                want_any_ack;
  } in_payload_t;

  // Result transfer payload
  typedef struct packed {
    logic [2:0]          subpacket_end;
    logic [3:0]          verdict;
    logic                window_full;
    logic [POS_BITS-1:0] send_position;
    logic [BLK_W-1:0]    block_length;
  } out_payload_t;

  // Classified item held in the queue
  typedef struct packed {
    op_t                 op;
    frame_t              kind;
    logic [BLK_W-1:0]    bytes;
    logic                eof;
    logic [POS_BITS-1:0] pos;
    logic                any_ack;
  } item_t;

  // Queue head as seen by the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Configuration write
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  // Limit a block length to the legal range
  function automatic logic [BLK_W-1:0] clamp_block(input logic [BLK_W-1:0] v);
    logic [BLK_W-1:0] r;
    if (v < BLK_W'(MIN_BLOCK)) begin
      r = BLK_W'(MIN_BLOCK);
    end else if (v > BLK_W'(MAX_BLOCK)) begin
      r = BLK_W'(MAX_BLOCK);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- sv/zmodem_sender_flow_control_top.sv -----
// Top level of the Zmodem sender data-phase flow controller.
// Depends on zsfc_pkg, zsfc_front and zsfc_back.
//
// The block takes one event per cycle while the queue has room and returns one
// result per event, in order. An input transfer is written into the two-entry
// queue of the front part; the back part then updates positions, credit and
// window fill and registers the result, one item per clock while the output
// does not stall. Configuration writes take effect at once and must be made
// while no event is in flight; writing the start block length also reloads the
// current block length, clamped to 32..8192.
module zmodem_sender_flow_control_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  zsfc_pkg::in_payload_t           in_payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output zsfc_pkg::out_payload_t          out_payload,
  input  logic                            cfg_we,
  input  logic [zsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zsfc_pkg::CFG_W-1:0]      cfg_data
);

  zsfc_pkg::queue_head_t head;
  zsfc_pkg::cfg_wr_t     cfg;
  logic                  pop;

  // Gather the configuration write
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Accept and classify events
  zsfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .head       (head),
    .pop        (pop)
  );

  // Carry out events and hold results
  zsfc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

// ----- sv/zsfc_front.sv -----
// Front part: accepts input transfers, classifies them and queues them.
// Depends on zsfc_pkg.
module zsfc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  zsfc_pkg::in_payload_t in_payload,
  output zsfc_pkg::queue_head_t head,
  input  logic                 pop
);

  zsfc_pkg::item_t               q_r [zsfc_pkg::QDEPTH];
  logic [zsfc_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [zsfc_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [zsfc_pkg::QPTR_W:0]     count_r, count_nxt;
  logic                          push;
  logic                          do_pop;
  zsfc_pkg::item_t               cls;

  // Classify the incoming transfer
  always_comb begin
    cls.eof     = in_payload.end_of_file;
    cls.pos     = in_payload.frame_position;
    cls.any_ack = in_payload.want_any_ack;
    if (in_payload.block_bytes > zsfc_pkg::BLK_W'(zsfc_pkg::MAX_BLOCK)) begin
      cls.bytes = zsfc_pkg::BLK_W'(zsfc_pkg::MAX_BLOCK);
    end else begin
      cls.bytes = in_payload.block_bytes;
    end
    case (in_payload.action)
      zsfc_pkg::ACT_SET_POS:   cls.op = zsfc_pkg::OP_SET_POS;
      zsfc_pkg::ACT_BEGIN_HDR: cls.op = zsfc_pkg::OP_BEGIN_HDR;
      zsfc_pkg::ACT_BLOCK:     cls.op = zsfc_pkg::OP_BLOCK;
      zsfc_pkg::ACT_HEADER:    cls.op = zsfc_pkg::OP_HEADER;
      zsfc_pkg::ACT_JUNK:      cls.op = zsfc_pkg::OP_JUNK;
      default:                 cls.op = zsfc_pkg::OP_NONE;
    endcase
    case (in_payload.frame_kind)
      zsfc_pkg::FRK_ACK:    cls.kind = zsfc_pkg::FR_ACK;
      zsfc_pkg::FRK_REPOS:  cls.kind = zsfc_pkg::FR_REPOS;
      zsfc_pkg::FRK_RINIT:  cls.kind = zsfc_pkg::FR_RINIT;
      zsfc_pkg::FRK_SKIP:   cls.kind = zsfc_pkg::FR_SKIP;
      zsfc_pkg::FRK_FATAL:  cls.kind = zsfc_pkg::FR_FATAL;
      zsfc_pkg::FRK_HANGUP: cls.kind = zsfc_pkg::FR_HANGUP;
      default:              cls.kind = zsfc_pkg::FR_OTHER;
    endcase
  end

  // Queue control
  always_comb begin
    in_stall   = (count_r == (zsfc_pkg::QPTR_W+1)'(zsfc_pkg::QDEPTH));
    push       = in_valid && !in_stall;
    do_pop     = pop && (count_r != '0);
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
    head.valid = (count_r != '0);
    head.item  = q_r[rd_ptr_r];
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- sv/zsfc_back.sv -----
// Back part: configuration registers, flow-control state and result register.
// Depends on zsfc_pkg; fed from the queue of zsfc_front.
module zsfc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  zsfc_pkg::cfg_wr_t     cfg,
  input  zsfc_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output zsfc_pkg::out_payload_t out_payload
);

  localparam int PW = zsfc_pkg::POS_BITS;
  localparam int BW = zsfc_pkg::BLK_W;
  localparam int CW = zsfc_pkg::CFG_W;
  localparam int FW = zsfc_pkg::FILL_W;

  // Configuration
  logic [CW-1:0] rx_buf_r, tx_win_r, ack_sp_r;

  // Flow-control state
  logic [PW-1:0] send_r, send_nxt;
  logic [PW-1:0] acked_r, acked_nxt;
  logic          sync_vld_r, sync_vld_nxt;
  logic [PW-1:0] sync_pt_r, sync_pt_nxt;
  logic [zsfc_pkg::RETRY_W-1:0] retry_r, retry_nxt, retry_inc;
  logic [BW-1:0] blk_r, blk_nxt;
  logic [CW-1:0] credit_r, credit_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW:0]   fill_sum;
  logic [FW-1:0] fill_sat;
  logic [zsfc_pkg::JUNK_W-1:0] junk_r, junk_nxt;
  logic [PW:0]   send_sum;

  // Result register
  logic          out_valid_r;
  logic [2:0]    o_sub_r, sub_nxt;
  logic [3:0]    o_vrd_r, vrd_nxt;
  logic [PW-1:0] o_send_r, o_acked_r;
  logic [BW-1:0] o_blk_r;
  logic [PW:0]   gap;

  zsfc_pkg::item_t it;
  logic            take;

  assign it   = head.item;
  assign take = head.valid && (!out_valid_r || !out_stall);
  assign pop  = take;

  // Next state for one item
  always_comb begin
    send_nxt     = send_r;
    acked_nxt    = acked_r;
    sync_vld_nxt = sync_vld_r;
    sync_pt_nxt  = sync_pt_r;
    retry_nxt    = retry_r;
    blk_nxt      = blk_r;
    credit_nxt   = credit_r;
    fill_nxt     = fill_r;
    junk_nxt     = junk_r;
    sub_nxt      = zsfc_pkg::SUB_NONE;
    vrd_nxt      = zsfc_pkg::VRD_NONE;
    send_sum     = {1'b0, send_r} + (PW+1)'(it.bytes);
    fill_sum     = {1'b0, fill_r} + (FW+1)'(it.bytes);
    fill_sat     = fill_sum[FW] ? {FW{1'b1}} : fill_sum[FW-1:0];
    retry_inc    = (retry_r < zsfc_pkg::RETRY_W'(zsfc_pkg::RETRY_MAX)) ?
                   retry_r + 1'b1 : retry_r;
    case (it.op)
      zsfc_pkg::OP_SET_POS: begin
        send_nxt     = it.pos;
        acked_nxt    = it.pos;
        sync_vld_nxt = (it.pos != '0);
        sync_pt_nxt  = it.pos - 1'b1;
        retry_nxt    = '0;
        junk_nxt     = '0;
      end
      zsfc_pkg::OP_BEGIN_HDR: begin
        credit_nxt = rx_buf_r;
        fill_nxt   = '0;
      end
      zsfc_pkg::OP_BLOCK: begin
        // Choose the subpacket end
        if (it.eof) begin
          sub_nxt = zsfc_pkg::SUB_CRCE;
        end else if (junk_r > zsfc_pkg::JUNK_W'(zsfc_pkg::JUNK_LIMIT)) begin
          sub_nxt = zsfc_pkg::SUB_CRCW;
        end else if (sync_vld_r && (send_r == sync_pt_r)) begin
          sub_nxt = zsfc_pkg::SUB_CRCW;
        end else if ((rx_buf_r != '0) && ((CW+1)'(it.bytes) >= (CW+1)'(credit_r))) begin
          credit_nxt = '0;
          sub_nxt    = zsfc_pkg::SUB_CRCW;
        end else begin
          if (rx_buf_r != '0) begin
            credit_nxt = credit_r - CW'(it.bytes);
          end
          sub_nxt = zsfc_pkg::SUB_CRCG;
          if (tx_win_r != '0) begin
            if (fill_sat >= FW'(ack_sp_r)) begin
              fill_nxt = '0;
              sub_nxt  = zsfc_pkg::SUB_CRCQ;
            end else begin
              fill_nxt = fill_sat;
            end
          end
        end
        // Advance the send position, saturating
        send_nxt = send_sum[PW] ? {PW{1'b1}} : send_sum[PW-1:0];
        if (sub_nxt == zsfc_pkg::SUB_CRCW) begin
          junk_nxt = '0;
        end
      end
      zsfc_pkg::OP_HEADER: begin
        case (it.kind)
          zsfc_pkg::FR_ACK: begin
            acked_nxt = it.pos;
            vrd_nxt   = (it.any_ack || (send_r == it.pos)) ?
                        zsfc_pkg::VRD_ACKED : zsfc_pkg::VRD_KEEP_WAIT;
          end
          zsfc_pkg::FR_REPOS: begin
            if (it.pos > send_r) begin
              vrd_nxt = zsfc_pkg::VRD_RX_AHEAD;
            end else begin
              send_nxt     = it.pos;
              acked_nxt    = it.pos;
              sync_pt_nxt  = it.pos;
              sync_vld_nxt = 1'b1;
              vrd_nxt      = zsfc_pkg::VRD_RESEND;
              if (sync_vld_r && (sync_pt_r == it.pos)) begin
                // Same position asked again: count the retry
                retry_nxt = retry_inc;
                if (retry_inc > zsfc_pkg::RETRY_W'(zsfc_pkg::RETRY_FATAL)) begin
                  vrd_nxt = zsfc_pkg::VRD_FATAL;
                end else if ((retry_inc > zsfc_pkg::RETRY_W'(zsfc_pkg::RETRY_HALVE)) &&
                             (blk_r > BW'(zsfc_pkg::MIN_BLOCK))) begin
                  blk_nxt = blk_r >> 1;
                end
              end else begin
                retry_nxt = '0;
              end
            end
          end
          zsfc_pkg::FR_RINIT:  vrd_nxt = zsfc_pkg::VRD_RINIT;
          zsfc_pkg::FR_SKIP:   vrd_nxt = zsfc_pkg::VRD_SKIP;
          zsfc_pkg::FR_FATAL:  vrd_nxt = zsfc_pkg::VRD_FATAL;
          zsfc_pkg::FR_HANGUP: vrd_nxt = zsfc_pkg::VRD_HANGUP;
          default:             vrd_nxt = zsfc_pkg::VRD_NAK_WAIT;
        endcase
      end
      zsfc_pkg::OP_JUNK: begin
        if (junk_r < zsfc_pkg::JUNK_W'(zsfc_pkg::JUNK_SAT)) begin
          junk_nxt = junk_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration registers; the block-length write also reloads the length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_buf_r <= '0;
      tx_win_r <= '0;
      ack_sp_r <= '0;
    end else if (cfg.we) begin
      case (cfg.index)
        zsfc_pkg::CFG_RX_BUFFER_LEN: rx_buf_r <= cfg.data;
        zsfc_pkg::CFG_TX_WINDOW:     tx_win_r <= cfg.data;
        zsfc_pkg::CFG_ACK_SPACING:   ack_sp_r <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Flow-control state, updated once per item taken from the queue; a start block-length write reloads the length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_r     <= '0;
      acked_r    <= '0;
      sync_vld_r <= 1'b0;
      sync_pt_r  <= '0;
      retry_r    <= '0;
      blk_r      <= zsfc_pkg::BLK_RESET;
      credit_r   <= '0;
      fill_r     <= '0;
      junk_r     <= '0;
    end else begin
      if (take) begin
        send_r     <= send_nxt;
        acked_r    <= acked_nxt;
        sync_vld_r <= sync_vld_nxt;
        sync_pt_r  <= sync_pt_nxt;
        retry_r    <= retry_nxt;
        credit_r   <= credit_nxt;
        fill_r     <= fill_nxt;
        junk_r     <= junk_nxt;
      end
      if (cfg.we && (cfg.index == zsfc_pkg::CFG_START_BLOCK_LEN)) begin
        blk_r <= zsfc_pkg::clamp_block(cfg.data[BW-1:0]);
      end else if (take) begin
        blk_r <= blk_nxt;
      end
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      o_sub_r   <= sub_nxt;
      o_vrd_r   <= vrd_nxt;
      o_send_r  <= send_nxt;
      o_acked_r <= acked_nxt;
      o_blk_r   <= blk_nxt;
    end
  end

  // Window-full flag from the registered positions
  always_comb begin
    gap                       = {1'b0, o_send_r} - {1'b0, o_acked_r};
    out_valid                 = out_valid_r;
    out_payload.subpacket_end = o_sub_r;
    out_payload.verdict       = o_vrd_r;
    out_payload.window_full   = (tx_win_r != '0) && !gap[PW] &&
                                (gap[PW-1:0] >= PW'(tx_win_r));
    out_payload.send_position = o_send_r;
    out_payload.block_length  = o_blk_r;
  end

endmodule

// ----- sv/zsfc_checker.sv -----
// Port checker for the Zmodem sender flow controller, bound to the top level.
// Depends on zsfc_pkg and zmodem_sender_flow_control_top_assert.svh.
`include "zmodem_sender_flow_control_top_assert.svh"

module zsfc_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input zsfc_pkg::out_payload_t out_payload
);

  // No result is offered just after reset
  `ZSFC_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result offered after reset")

  // A stalled result stays offered
  `ZSFC_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")

  // A block result carries no verdict and a header result no subpacket end
  `ZSFC_ASSERT(a_one_kind, out_valid |-> (out_payload.subpacket_end == zsfc_pkg::SUB_NONE) || (out_payload.verdict == zsfc_pkg::VRD_NONE), "both subpacket end and verdict set")

  // Codes stay within their defined ranges
  `ZSFC_ASSERT(a_codes, out_valid |-> (out_payload.subpacket_end <= zsfc_pkg::SUB_CRCE) && (out_payload.verdict <= zsfc_pkg::VRD_HANGUP), "undefined result code")

  // Block length stays at or below the maximum; halving from just above the
  // minimum can take it down to half the minimum, but never further.
  `ZSFC_ASSERT(a_blk_range, out_valid |-> (out_payload.block_length >= zsfc_pkg::BLK_W'(zsfc_pkg::MIN_BLOCK / 2)) && (out_payload.block_length <= zsfc_pkg::BLK_W'(zsfc_pkg::MAX_BLOCK)), "block length out of range")

endmodule

bind zmodem_sender_flow_control_top zsfc_checker u_zsfc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload)
);

// ----- tb/sv/tb_zmodem_sender_flow_control_top.sv -----
// Self-checking testbench for the Zmodem sender data-phase flow controller.
// Depends on zsfc_pkg and zmodem_sender_flow_control_top; it needs no other file.
// A directed table runs first, then random event mixes under several register settings.
module tb_zmodem_sender_flow_control_top;
  import zsfc_pkg::*;

  // Codes that the package leaves unnamed
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam logic [2:0] FRK_OTHER     = 3'd6;
  localparam logic [2:0] FRK_SPARE     = 3'd7;
  localparam logic [POS_BITS-1:0] POS_TOP = '1;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 190;

  typedef struct {
    in_payload_t  ev;
    bit           typed;
    out_payload_t want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_payload_t          in_payload;
  logic                 out_valid;
  logic                 out_stall;
  out_payload_t         out_payload;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Predictor copy of the registers and the flow state
  logic [15:0]         rxbuf_len, win_len, ack_gap;
  logic [POS_BITS-1:0] tx_pos, ack_pos, sync_pos;
  logic                sync_ok;
  logic [3:0]          retries;
  logic [BLK_W-1:0]    blk_len;
  logic [17:0]         credit;
  logic [16:0]         fill;
  logic [2:0]          junk;

  out_payload_t due_results[$];
  stim_row_t    rows[$];
  logic         hand_use;
  out_payload_t hand_want;
  logic         tx_quiet, rx_quiet, squeeze_req;
  int           bad_fields, results_seen, events_in, events_sent, settings_used;
  int           end_seen[8];
  int           verdict_seen[16];

  zmodem_sender_flow_control_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Subpacket end chosen for one block read; updates credit and window fill.
  function automatic logic [2:0] pick_end(input logic [BLK_W-1:0] n, input logic eof);
    logic [17:0] sum;
    if (eof) return SUB_CRCE;
    if (junk > JUNK_LIMIT) return SUB_CRCW;
    if (sync_ok && tx_pos == sync_pos) return SUB_CRCW;
    if (rxbuf_len != 0) begin
      if (18'(n) >= credit) begin
        credit = '0;
        return SUB_CRCW;
      end
      credit = credit - 18'(n);
    end
    if (win_len != 0) begin
      sum = 18'(fill) + 18'(n);
      fill = (sum > 18'h1FFFF) ? 17'h1FFFF : sum[16:0];
      if (fill >= 17'(ack_gap)) begin
        fill = '0;
        return SUB_CRCQ;
      end
    end
    return SUB_CRCG;
  endfunction

  // Verdict on a received header, with reposition retry counting.
  function automatic logic [3:0] frame_verdict(input logic [2:0] kind,
                                               input logic [POS_BITS-1:0] pos,
                                               input logic any);
    case (kind)
      FRK_ACK: begin
        ack_pos = pos;
        return (any || tx_pos == pos) ? VRD_ACKED : VRD_KEEP_WAIT;
      end
      FRK_REPOS: begin
        if (pos > tx_pos) return VRD_RX_AHEAD;
        tx_pos  = pos;
        ack_pos = pos;
        if (sync_ok && sync_pos == pos) begin
          if (retries < RETRY_MAX) retries++;
          if (retries > RETRY_FATAL) return VRD_FATAL;
          if (retries > RETRY_HALVE && blk_len > MIN_BLOCK) blk_len = blk_len >> 1;
        end else begin
          retries = '0;
        end
        sync_pos = pos;
        sync_ok  = 1'b1;
        return VRD_RESEND;
      end
      FRK_RINIT:  return VRD_RINIT;
      FRK_SKIP:   return VRD_SKIP;
      FRK_FATAL:  return VRD_FATAL;
      FRK_HANGUP: return VRD_HANGUP;
      default:    return VRD_NAK_WAIT;
    endcase
  endfunction

  // Result of one event, advancing the predictor state.
  function automatic out_payload_t flow_step(input in_payload_t ev);
    out_payload_t     r;
    logic [BLK_W-1:0] n;
    logic [31:0]      nxt;
    r = '0;
    case (ev.action)
      ACT_SET_POS: begin
        tx_pos   = ev.frame_position;
        ack_pos  = ev.frame_position;
        sync_ok  = (ev.frame_position != 0);
        sync_pos = sync_ok ? ev.frame_position - 1'b1 : '0;
        retries  = '0;
        junk     = '0;
      end
      ACT_BEGIN_HDR: begin
        credit = 18'(rxbuf_len);
        fill   = '0;
      end
      ACT_BLOCK: begin
        n = (ev.block_bytes > MAX_BLOCK) ? BLK_W'(MAX_BLOCK) : ev.block_bytes;
        r.subpacket_end = pick_end(n, ev.end_of_file);
        nxt = 32'(tx_pos) + 32'(n);
        tx_pos = (nxt > 32'(POS_TOP)) ? POS_TOP : nxt[POS_BITS-1:0];
        if (r.subpacket_end == SUB_CRCW) junk = '0;
      end
      ACT_HEADER: r.verdict = frame_verdict(ev.frame_kind, ev.frame_position, ev.want_any_ack);
      ACT_JUNK: if (junk < JUNK_SAT) junk++;
      default: ;
    endcase
    r.window_full   = (win_len != 0) && (tx_pos >= ack_pos) &&
                      ((tx_pos - ack_pos) >= POS_BITS'(win_len));
    r.send_position = tx_pos;
    r.block_length  = blk_len;
    return r;
  endfunction

  // Register write as the predictor sees it.
  function automatic void take_setting(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] value);
    logic [BLK_W-1:0] v;
    v = value[BLK_W-1:0];
    case (idx)
      CFG_RX_BUFFER_LEN: rxbuf_len = value;
      CFG_TX_WINDOW:     win_len   = value;
      CFG_ACK_SPACING:   ack_gap   = value;
      CFG_START_BLOCK_LEN: begin
        if (v < MIN_BLOCK) blk_len = BLK_W'(MIN_BLOCK);
        else if (v > MAX_BLOCK) blk_len = BLK_W'(MAX_BLOCK);
        else blk_len = v;
      end
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (bad_fields < 40)
      $display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want,
               results_seen);
    bad_fields++;
  endtask

  // Sample both channels and the register port; predict and compare.
  always @(posedge clk) begin : scoreboard
    out_payload_t want;
    if (rst_n) begin
      if (cfg_we) take_setting(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        want = flow_step(in_payload);
        if (hand_use) want = hand_want;
        due_results.push_back(want);
        events_in++;
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          note_mismatch("unexpected transfer", 32'(out_payload.send_position), '0);
        end else begin
          want = due_results.pop_front();
          if (out_payload.subpacket_end !== want.subpacket_end)
            note_mismatch("subpacket end", out_payload.subpacket_end, want.subpacket_end);
          if (out_payload.verdict !== want.verdict)
            note_mismatch("verdict", out_payload.verdict, want.verdict);
          if (out_payload.window_full !== want.window_full)
            note_mismatch("window full", out_payload.window_full, want.window_full);
          if (out_payload.send_position !== want.send_position)
            note_mismatch("send position", out_payload.send_position, want.send_position);
          if (out_payload.block_length !== want.block_length)
            note_mismatch("block length", out_payload.block_length, want.block_length);
          end_seen[want.subpacket_end]++;
          verdict_seen[want.verdict]++;
        end
        results_seen++;
      end
    end
  end

  // Receiver side: random stalls, and one long hold-off on request.
  initial begin : rx_side
    int hold_left;
    int r;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left = SQUEEZE_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          hold_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 29);
        end
      end
    end
  end

  function automatic int idle_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_payload_t noise();
    in_payload_t p;
    p.action         = 3'($urandom);
    p.block_bytes    = BLK_W'($urandom);
    p.end_of_file    = 1'($urandom);
    p.frame_kind     = 3'($urandom);
    p.frame_position = POS_BITS'($urandom);
    p.want_any_ack   = 1'($urandom);
    return p;
  endfunction

  function automatic in_payload_t item_of(input logic [2:0] act, input logic [BLK_W-1:0] bytes,
                                          input logic eof, input logic [2:0] kind,
                                          input logic [POS_BITS-1:0] pos, input logic any);
    in_payload_t p;
    p.action         = act;
    p.block_bytes    = bytes;
    p.end_of_file    = eof;
    p.frame_kind     = kind;
    p.frame_position = pos;
    p.want_any_ack   = any;
    return p;
  endfunction

  function automatic out_payload_t want_of(input logic [2:0] sub, input logic [3:0] vrd,
                                           input logic full, input logic [POS_BITS-1:0] pos,
                                           input logic [BLK_W-1:0] blk);
    out_payload_t r;
    r.subpacket_end = sub;
    r.verdict       = vrd;
    r.window_full   = full;
    r.send_position = pos;
    r.block_length  = blk;
    return r;
  endfunction

  function automatic logic [POS_BITS-1:0] back_off(input logic [POS_BITS-1:0] p,
                                                   input int unsigned d);
    return (p >= d) ? p - POS_BITS'(d) : '0;
  endfunction

  // Offer one event from a falling edge and hold it until the transfer.
  task automatic push_event(input in_payload_t ev);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic push_block();
    in_payload_t p;
    p = noise();
    p.action      = ACT_BLOCK;
    p.block_bytes = ($urandom_range(0, 9) == 0) ? BLK_W'($urandom_range(0, 16383))
                                                : BLK_W'($urandom_range(0, blk_len));
    p.end_of_file = ($urandom_range(0, 11) == 0);
    push_event(p);
  endtask

  // Random mix: mostly well-formed data-phase traffic, some broken and noisy items.
  task automatic run_mix(input int count);
    int goal, r, reps;
    in_payload_t p;
    logic [POS_BITS-1:0] pos;
    goal = events_sent + count;
    while (events_sent < goal) begin
      r = $urandom_range(0, 99);
      p = noise();
      if (r < 45) begin
        push_block();
      end else if (r < 53) begin
        p.action = ACT_BEGIN_HDR;
        push_event(p);
      end else if (r < 63) begin
        p.action     = ACT_HEADER;
        p.frame_kind = FRK_ACK;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: p.frame_position = tx_pos;
          5, 6, 7:       p.frame_position = back_off(tx_pos, $urandom_range(0, 20000));
          default: ;
        endcase
        p.want_any_ack = ($urandom_range(0, 3) == 0);
        push_event(p);
      end else if (r < 67) begin
        // Reposition storm at one position, as a stuck receiver would send
        pos = back_off(tx_pos, $urandom_range(0, 3000));
        if (pos != POS_TOP && $urandom_range(0, 1) == 1)
          push_event(item_of(ACT_SET_POS, BLK_W'($urandom), 1'($urandom), 3'($urandom),
                             pos + 1'b1, 1'($urandom)));
        reps = $urandom_range(2, 16);
        repeat (reps) begin
          push_event(item_of(ACT_HEADER, BLK_W'($urandom), 1'($urandom), FRK_REPOS, pos,
                             1'($urandom)));
          if ($urandom_range(0, 9) < 4) push_block();
        end
      end else if (r < 73) begin
        p.action = ACT_SET_POS;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: p.frame_position = POS_BITS'($urandom_range(0, 4096));
          4, 5:       p.frame_position = POS_TOP - POS_BITS'($urandom_range(0, 20000));
          6:          p.frame_position = '0;
          default: ;
        endcase
        push_event(p);
      end else if (r < 78) begin
        reps = $urandom_range(1, 6);
        repeat (reps) begin
          p = noise();
          p.action = ACT_JUNK;
          push_event(p);
        end
        push_block();
      end else if (r < 85) begin
        p.action     = ACT_HEADER;
        p.frame_kind = 3'($urandom_range(FRK_REPOS, FRK_SPARE));
        push_event(p);
      end else if (r < 88) begin
        p.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        push_event(p);
      end else begin
        push_event(p);
      end
    end
  endtask

  // Register writes on consecutive falling edges; entered at a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic settle(input logic [15:0] rx, input logic [15:0] win,
                        input logic [15:0] spacing, input logic [15:0] blk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    @(negedge clk);
    write_reg(CFG_RX_BUFFER_LEN, rx);
    write_reg(CFG_TX_WINDOW, win);
    write_reg(CFG_ACK_SPACING, spacing);
    write_reg(CFG_START_BLOCK_LEN, blk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Run limit
  initial begin
    #2000000;
    $display("tb_zmodem_sender_flow_control_top: errors");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    int i, ph;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_payload  = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_RX_BUFFER_LEN;
    cfg_data    = '0;
    hand_use    = 1'b0;
    hand_want   = '0;
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    squeeze_req = 1'b0;
    bad_fields  = 0;
    results_seen = 0;
    events_in   = 0;
    events_sent = 0;
    settings_used = 1;
    rxbuf_len = '0;
    win_len   = '0;
    ack_gap   = '0;
    tx_pos    = '0;
    ack_pos   = '0;
    sync_pos  = '0;
    sync_ok   = 1'b0;
    retries   = '0;
    blk_len   = BLK_RESET;
    credit    = '0;
    fill      = '0;
    junk      = '0;

    // Directed table; typed results assume the register values after reset.
    rows.push_back('{item_of(ACT_BLOCK, '0, 1'b0, FRK_ACK, '0, 1'b0), 1'b1,
                     want_of(SUB_CRCG, VRD_NONE, 1'b0, '0, BLK_RESET)});
    rows.push_back('{item_of(ACT_SET_POS, '1, 1'b1, FRK_SPARE, POS_TOP - 15, 1'b1), 1'b1,
                     want_of(SUB_NONE, VRD_NONE, 1'b0, POS_TOP - 15, BLK_RESET)});
    rows.push_back('{item_of(ACT_BLOCK, '1, 1'b1, FRK_ACK, '0, 1'b0), 1'b1,
                     want_of(SUB_CRCE, VRD_NONE, 1'b0, POS_TOP, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_ACK, POS_TOP, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_ACKED, 1'b0, POS_TOP, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_REPOS, POS_TOP, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_RESEND, 1'b0, POS_TOP, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '1, 1'b1, FRK_REPOS, POS_TOP, 1'b1), 1'b0, '0});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_ACK, 5, 1'b1), 1'b1,
                     want_of(SUB_NONE, VRD_ACKED, 1'b0, POS_TOP, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_ACK, 5, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_KEEP_WAIT, 1'b0, POS_TOP, BLK_RESET)});
    rows.push_back('{item_of(ACT_SET_POS, '0, 1'b0, FRK_ACK, '0, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_NONE, 1'b0, '0, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_REPOS, 1, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_RX_AHEAD, 1'b0, '0, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_RINIT, '0, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_RINIT, 1'b0, '0, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_SKIP, '0, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_SKIP, 1'b0, '0, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_FATAL, '0, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_FATAL, 1'b0, '0, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_HANGUP, '0, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_HANGUP, 1'b0, '0, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_OTHER, '0, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_NAK_WAIT, 1'b0, '0, BLK_RESET)});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_SPARE, '0, 1'b0), 1'b1,
                     want_of(SUB_NONE, VRD_NAK_WAIT, 1'b0, '0, BLK_RESET)});
    // Junk count saturates, then forces a wait subpacket
    repeat (5) rows.push_back('{item_of(ACT_JUNK, '0, 1'b0, FRK_ACK, '0, 1'b0), 1'b0, '0});
    rows.push_back('{item_of(ACT_BLOCK, 14'd100, 1'b0, FRK_ACK, '0, 1'b0), 1'b1,
                     want_of(SUB_CRCW, VRD_NONE, 1'b0, 31'd100, BLK_RESET)});
    rows.push_back('{item_of(ACT_UNUSED_HI, '1, 1'b1, FRK_SPARE, POS_TOP, 1'b1), 1'b1,
                     want_of(SUB_NONE, VRD_NONE, 1'b0, 31'd100, BLK_RESET)});
    // Resend to the sync point gives a wait subpacket
    rows.push_back('{item_of(ACT_SET_POS, '0, 1'b0, FRK_ACK, 31'd1000, 1'b0), 1'b0, '0});
    rows.push_back('{item_of(ACT_HEADER, '0, 1'b0, FRK_REPOS, 31'd999, 1'b0), 1'b0, '0});
    rows.push_back('{item_of(ACT_BLOCK, 14'd64, 1'b0, FRK_ACK, '0, 1'b0), 1'b0, '0});
    rows.push_back('{item_of(ACT_BEGIN_HDR, '0, 1'b0, FRK_ACK, '0, 1'b0), 1'b0, '0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < rows.size(); i++) begin
      hand_use  = rows[i].typed;
      hand_want = rows[i].want;
      push_event(rows[i].ev);
    end
    hand_use = 1'b0;

    // Random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: settle(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: settle('0, '0, '0, '0);
        3: settle(16'd100, 16'd300, 16'd64, 16'd16);
        4: settle(16'd1, 16'd1, 16'd0, 16'd32);
        5: settle(16'd4096, 16'd8192, 16'd1024, 16'd8192);
        default: settle(16'($urandom_range(0, 2000)), 16'($urandom),
                        16'($urandom_range(0, 4096)), 16'($urandom_range(0, 9000)));
      endcase
      tx_quiet = (ph == 2) || (ph == 4);
      rx_quiet = (ph == 2);
      if (ph == 4) squeeze_req = 1'b1;
      run_mix(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d events and %0d checked results under %0d register settings.",
             events_in, results_seen, settings_used);
    $display("Ends: go-on %0d, ack request %0d, wait %0d, end frame %0d; resends %0d, fatal %0d.",
             end_seen[SUB_CRCG], end_seen[SUB_CRCQ], end_seen[SUB_CRCW], end_seen[SUB_CRCE],
             verdict_seen[VRD_RESEND], verdict_seen[VRD_FATAL]);
    if (bad_fields == 0) begin
      $display("tb_zmodem_sender_flow_control_top: clean");
    end else begin
      $display("tb_zmodem_sender_flow_control_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/zsfc_pkg.sv
sv/zsfc_front.sv
sv/zsfc_back.sv
sv/zmodem_sender_flow_control_top.sv
sv/zsfc_checker.sv
tb/sv/tb_zmodem_sender_flow_control_top.sv
